// File: hdl/cdrc_pkg.sv
// shared types and codes for the chunked download retry controller
// no dependencies; imported by cdrc_engine and the top level
package cdrc_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LEN_BITS    = 16;
  localparam int TIMER_BITS  = 16;
  localparam int ATT_BITS    = 4;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  // register indexes
  localparam logic [1:0] REG_PERMIT_WAIT = 2'd0;
  localparam logic [1:0] REG_CHUNK_WAIT  = 2'd1;
  localparam logic [1:0] REG_MAX_ATT     = 2'd2;
  localparam logic [1:0] REG_CHUNK_MAX   = 2'd3;

  // event kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_UPDATE  = 3'd1;
  localparam logic [2:0] KIND_ENABLE  = 3'd2;
  localparam logic [2:0] KIND_SEGMENT = 3'd3;
  localparam logic [2:0] KIND_ABORT   = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_FETCH = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE           = 4'd0,
    ACT_ANNOUNCE       = 4'd1,
    ACT_START          = 4'd2,
    ACT_NEXT           = 4'd3,
    ACT_RETRY          = 4'd4,
    ACT_SUCCESS        = 4'd5,
    ACT_VALIDATE_FAIL  = 4'd6,
    ACT_WRITE_FAIL     = 4'd7,
    ACT_INIT_FAIL      = 4'd8,
    ACT_PERMIT_TIMEOUT = 4'd9,
    ACT_GAVE_UP        = 4'd10,
    ACT_ABORT          = 4'd11
  } action_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [OFFSET_BITS-1:0] total_length;
    logic [OFFSET_BITS-1:0] seg_start;
    logic [LEN_BITS-1:0]    seg_length;
    logic                   op_ok;
    logic                   validate_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0]             action;
    logic [OFFSET_BITS-1:0] req_offset;
    logic [LEN_BITS-1:0]    req_length;
    logic [1:0]             phase_out;
  } out_item_t;

  typedef struct packed {
    logic [TIMER_BITS-1:0] permit_wait_ticks;
    logic [TIMER_BITS-1:0] chunk_wait_ticks;
    logic [ATT_BITS-1:0]   max_attempts;
    logic [LEN_BITS-1:0]   chunk_max_len;
  } cfg_t;

endpackage

// File: hdl/cdrc_engine.sv
// download state and the per-item decision logic
// depends on cdrc_pkg; state moves only when step is high
module cdrc_engine import cdrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  phase_t                 phase, phase_next;
  logic [TIMER_BITS-1:0]  wait_timer, wait_timer_next;
  logic [ATT_BITS-1:0]    attempt_count, attempt_count_next;
  logic [OFFSET_BITS-1:0] current_offset, current_offset_next;
  logic [OFFSET_BITS-1:0] image_length, image_length_next;

  action_t                action;
  logic [TIMER_BITS-1:0]  timer_dec;
  logic [ATT_BITS-1:0]    att_inc;
  logic [OFFSET_BITS:0]   seg_sum;
  logic [OFFSET_BITS-1:0] seg_end;
  logic [OFFSET_BITS-1:0] req_base;
  logic [OFFSET_BITS-1:0] req_rem;
  logic [LEN_BITS-1:0]    req_len;
  logic                   req_on;

  assign timer_dec = wait_timer - TIMER_BITS'(1);
  assign att_inc   = (attempt_count == '1) ? attempt_count : attempt_count + ATT_BITS'(1);
  assign seg_sum   = (OFFSET_BITS+1)'(current_offset) + (OFFSET_BITS+1)'(item.seg_length);
  // offset saturates at the top of the offset range
  assign seg_end   = seg_sum[OFFSET_BITS] ? '1 : seg_sum[OFFSET_BITS-1:0];

  // decision for the current item
  always_comb begin
    action = ACT_NONE;
    unique case (item.kind)
      KIND_TICK: begin
        if (phase != PH_IDLE && timer_dec == '0) begin
          if (phase == PH_WAIT) begin
            action = ACT_PERMIT_TIMEOUT;
          end else if (att_inc < cfg.max_attempts) begin
            action = ACT_RETRY;
          end else begin
            action = ACT_GAVE_UP;
          end
        end
      end
      KIND_UPDATE: action = ACT_ANNOUNCE;
      KIND_ENABLE: begin
        if (phase == PH_WAIT) begin
          action = item.op_ok ? ACT_START : ACT_INIT_FAIL;
        end
      end
      KIND_SEGMENT: begin
        if (phase == PH_FETCH && item.seg_start == current_offset) begin
          if (!item.op_ok) begin
            action = ACT_WRITE_FAIL;
          end else if (seg_end >= image_length) begin
            action = item.validate_ok ? ACT_SUCCESS : ACT_VALIDATE_FAIL;
          end else begin
            action = ACT_NEXT;
          end
        end
      end
      KIND_ABORT: action = ACT_ABORT;
      default:    action = ACT_NONE;
    endcase
  end

  // chunk request from the offset that holds after this item
  always_comb begin
    unique case (item.kind)
      KIND_ENABLE:  req_base = '0;
      KIND_SEGMENT: req_base = seg_end;
      default:      req_base = current_offset;
    endcase
    req_rem = (image_length > req_base) ? image_length - req_base : '0;
    req_len = (req_rem > OFFSET_BITS'(cfg.chunk_max_len)) ? cfg.chunk_max_len
                                                           : req_rem[LEN_BITS-1:0];
    req_on  = (action == ACT_START) || (action == ACT_NEXT) || (action == ACT_RETRY);
  end

  // next state
  always_comb begin
    phase_next          = phase;
    wait_timer_next     = wait_timer;
    attempt_count_next  = attempt_count;
    current_offset_next = current_offset;
    image_length_next   = image_length;
    unique case (action)
      ACT_NONE: begin
        if (item.kind == KIND_TICK && phase != PH_IDLE) begin
          wait_timer_next = timer_dec;
        end
      end
      ACT_ANNOUNCE: begin
        image_length_next = item.total_length;
        wait_timer_next   = cfg.permit_wait_ticks;
        phase_next        = PH_WAIT;
      end
      ACT_START: begin
        current_offset_next = '0;
        attempt_count_next  = '0;
        wait_timer_next     = cfg.chunk_wait_ticks;
        phase_next          = PH_FETCH;
      end
      ACT_NEXT: begin
        current_offset_next = seg_end;
        attempt_count_next  = '0;
        wait_timer_next     = cfg.chunk_wait_ticks;
      end
      ACT_RETRY: begin
        attempt_count_next = att_inc;
        wait_timer_next    = cfg.chunk_wait_ticks;
      end
      ACT_SUCCESS, ACT_VALIDATE_FAIL: begin
        current_offset_next = seg_end;
        phase_next          = PH_IDLE;
      end
      ACT_GAVE_UP: begin
        attempt_count_next = att_inc;
        wait_timer_next    = timer_dec;
        phase_next         = PH_IDLE;
      end
      ACT_PERMIT_TIMEOUT: begin
        wait_timer_next = timer_dec;
        phase_next      = PH_IDLE;
      end
      ACT_WRITE_FAIL, ACT_INIT_FAIL, ACT_ABORT: phase_next = PH_IDLE;
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    result.action     = action;
    result.req_offset = req_on ? req_base : '0;
    result.req_length = req_on ? req_len : '0;
    result.phase_out  = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      wait_timer     <= '0;
      attempt_count  <= '0;
      current_offset <= '0;
      image_length   <= '0;
    end else if (step) begin
      phase          <= phase_next;
      wait_timer     <= wait_timer_next;
      attempt_count  <= attempt_count_next;
      current_offset <= current_offset_next;
      image_length   <= image_length_next;
    end
  end

endmodule

// File: hdl/chunked_download_retry_controller_unit.sv
// Chunked download retry controller. Each event item (tick, update request,
// enable, segment, abort) yields exactly one result item with an action code,
// the next chunk request and the phase after the event. An item is held in the
// input register and its result is registered into the output register when
// the item advances, and one item is taken every cycle while the output side
// keeps up; throughput is set only by out_ready. Registers on
// the APB port (permit wait, chunk wait, max attempts, chunk max length) sit at
// byte addresses 0, 4, 8, 12 and should be written only when no item is in flight.
// depends on cdrc_pkg and cdrc_engine
module chunked_download_retry_controller_unit import cdrc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  in_item_t  s1_item;
  logic      s1_valid;
  logic      advance;
  out_item_t result;
  logic      cfg_write;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_AW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.permit_wait_ticks <= TIMER_BITS'(1000);
      cfg.chunk_wait_ticks  <= TIMER_BITS'(100);
      cfg.max_attempts      <= ATT_BITS'(3);
      cfg.chunk_max_len     <= LEN_BITS'(4096);
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_PERMIT_WAIT: cfg.permit_wait_ticks <= pwdata[TIMER_BITS-1:0];
        REG_CHUNK_WAIT:  cfg.chunk_wait_ticks  <= pwdata[TIMER_BITS-1:0];
        REG_MAX_ATT:     cfg.max_attempts      <= pwdata[ATT_BITS-1:0];
        REG_CHUNK_MAX:   cfg.chunk_max_len     <= pwdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PERMIT_WAIT: prdata = APB_DW'(cfg.permit_wait_ticks);
      REG_CHUNK_WAIT:  prdata = APB_DW'(cfg.chunk_wait_ticks);
      REG_MAX_ATT:     prdata = APB_DW'(cfg.max_attempts);
      REG_CHUNK_MAX:   prdata = APB_DW'(cfg.chunk_max_len);
      default:         prdata = '0;
    endcase
  end

  // item moves from the input register to the output register
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  cdrc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_req_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(out_data.action == ACT_START || out_data.action == ACT_NEXT ||
                   out_data.action == ACT_RETRY)
    |-> out_data.req_offset == '0 && out_data.req_length == '0)
    else $error("request fields set on an action without a request");

  a_req_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.req_length <= cfg.chunk_max_len)
    else $error("chunk request longer than the chunk maximum");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.action == ACT_SUCCESS || out_data.action == ACT_GAVE_UP ||
                  out_data.action == ACT_ABORT || out_data.action == ACT_WRITE_FAIL)
    |-> out_data.phase_out == PH_IDLE)
    else $error("terminal action left the controller busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("stalled item lost from the input register");
`endif

endmodule

// File: test/chunked_download_retry_controller_unit_tb.sv
// testbench for chunked_download_retry_controller_unit: directed table, then random
// download sessions checked against an in-bench model of the controller
// depends on cdrc_pkg and the rtl under hdl/
`timescale 1ns / 100ps

module chunked_download_retry_controller_unit_tb;
  import cdrc_pkg::*;

  localparam int LIMIT_NS = 3_000_000;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [15:0] val;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // controller model
  logic [15:0]            m_cfg [4];
  phase_t                 m_phase;
  logic [TIMER_BITS-1:0]  m_timer;
  logic [ATT_BITS-1:0]    m_att;
  logic [OFFSET_BITS-1:0] m_off;
  logic [OFFSET_BITS-1:0] m_len;

  out_item_t expected_actions [$];
  plan_row_t script [$];
  bit        steady = 1'b0;
  bit [11:0] seen_act = '0;
  int        n_items = 0;
  int        n_results = 0;
  int        n_writes = 0;
  int        n_mism = 0;

  chunked_download_retry_controller_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic void reset_model();
    m_cfg[REG_PERMIT_WAIT] = 16'd1000;
    m_cfg[REG_CHUNK_WAIT]  = 16'd100;
    m_cfg[REG_MAX_ATT]     = 16'd3;
    m_cfg[REG_CHUNK_MAX]   = 16'd4096;
    m_phase = PH_IDLE;
    m_timer = '0;
    m_att   = '0;
    m_off   = '0;
    m_len   = '0;
  endfunction

  // remaining length capped at the chunk maximum, zero once past the end
  function automatic logic [LEN_BITS-1:0] chunk_len();
    logic [OFFSET_BITS-1:0] left;
    left = (m_len > m_off) ? m_len - m_off : '0;
    return (left > {8'd0, m_cfg[REG_CHUNK_MAX]}) ? m_cfg[REG_CHUNK_MAX] : left[15:0];
  endfunction

  function automatic out_item_t advance_download(in_item_t e);
    out_item_t r;
    r = '0;
    case (e.kind)
      KIND_TICK: begin
        if (m_phase != PH_IDLE) begin
          m_timer = m_timer - 1'b1;
          if (m_timer == '0) begin
            if (m_phase == PH_WAIT) begin
              r.action = ACT_PERMIT_TIMEOUT;
              m_phase = PH_IDLE;
            end else begin
              if (m_att != 4'hF) m_att = m_att + 1'b1;
              if (m_att < m_cfg[REG_MAX_ATT][3:0]) begin
                r.action = ACT_RETRY;
                r.req_offset = m_off;
                r.req_length = chunk_len();
                m_timer = m_cfg[REG_CHUNK_WAIT];
              end else begin
                r.action = ACT_GAVE_UP;
                m_phase = PH_IDLE;
              end
            end
          end
        end
      end
      KIND_UPDATE: begin
        m_len = e.total_length;
        m_timer = m_cfg[REG_PERMIT_WAIT];
        m_phase = PH_WAIT;
        r.action = ACT_ANNOUNCE;
      end
      KIND_ENABLE: begin
        if (m_phase == PH_WAIT) begin
          if (e.op_ok) begin
            m_off = '0;
            m_att = '0;
            r.action = ACT_START;
            r.req_offset = m_off;
            r.req_length = chunk_len();
            m_timer = m_cfg[REG_CHUNK_WAIT];
            m_phase = PH_FETCH;
          end else begin
            r.action = ACT_INIT_FAIL;
            m_phase = PH_IDLE;
          end
        end
      end
      KIND_SEGMENT: begin
        if (m_phase == PH_FETCH && e.seg_start == m_off) begin
          if (e.op_ok) begin
            if ({8'd0, e.seg_length} > {OFFSET_BITS{1'b1}} - m_off) m_off = {OFFSET_BITS{1'b1}};
            else m_off = m_off + {8'd0, e.seg_length};
            if (m_off >= m_len) begin
              r.action = e.validate_ok ? ACT_SUCCESS : ACT_VALIDATE_FAIL;
              m_phase = PH_IDLE;
            end else begin
              m_att = '0;
              r.action = ACT_NEXT;
              r.req_offset = m_off;
              r.req_length = chunk_len();
              m_timer = m_cfg[REG_CHUNK_WAIT];
            end
          end else begin
            r.action = ACT_WRITE_FAIL;
            m_phase = PH_IDLE;
          end
        end
      end
      KIND_ABORT: begin
        r.action = ACT_ABORT;
        m_phase = PH_IDLE;
      end
      default: ;
    endcase
    r.phase_out = m_phase;
    return r;
  endfunction

  function automatic in_item_t ev(logic [2:0] k, logic [23:0] tot, logic [23:0] st,
                                  logic [15:0] ln, logic ok, logic vok);
    return {k, tot, st, ln, ok, vok};
  endfunction

  function automatic out_item_t res(action_t a, logic [23:0] o, logic [15:0] l, phase_t p);
    return {a, o, l, p};
  endfunction

  function automatic void add_event(in_item_t e, bit typed, out_item_t w);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    r.item   = e;
    r.typed  = typed;
    r.want   = w;
    script.push_back(r);
  endfunction

  function automatic void add_reg(logic [1:0] idx, logic [15:0] val);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.item   = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    script.push_back(r);
  endfunction

  function automatic void log_mismatch(string what, string detail);
    n_mism++;
    if (n_mism <= 10) $display("%0t: %s: %s", $realtime, what, detail);
  endfunction

  function automatic logic [23:0] image_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'($urandom);
      default: return 24'($urandom_range(1, 4 * int'(m_cfg[REG_CHUNK_MAX])));
    endcase
  endfunction

  // mostly events that fit the current phase, with some noise mixed in
  function automatic in_item_t pick_event();
    in_item_t e;
    int unsigned roll;
    e.kind         = KIND_TICK;
    e.total_length = 24'($urandom);
    e.seg_start    = 24'($urandom);
    e.seg_length   = 16'($urandom);
    e.op_ok        = 1'($urandom);
    e.validate_ok  = 1'($urandom);
    if ($urandom_range(0, 99) < 8) begin
      e.kind = 3'($urandom);
      return e;
    end
    roll = $urandom_range(0, 99);
    case (m_phase)
      PH_IDLE: begin
        if (roll < 80) begin
          e.kind = KIND_UPDATE;
          e.total_length = image_size();
        end else if (roll < 90) e.kind = KIND_TICK;
        else if (roll < 95) e.kind = KIND_ABORT;
        else e.kind = KIND_SEGMENT;
      end
      PH_WAIT: begin
        if (roll < 65) begin
          e.kind = KIND_ENABLE;
          e.op_ok = ($urandom_range(0, 9) != 0);
        end else if (roll < 90) e.kind = KIND_TICK;
        else if (roll < 95) begin
          e.kind = KIND_UPDATE;
          e.total_length = image_size();
        end else e.kind = KIND_ABORT;
      end
      default: begin
        if (roll < 65) begin
          e.kind = KIND_SEGMENT;
          if ($urandom_range(0, 9) != 0) e.seg_start = m_off;
          if ($urandom_range(0, 9) < 7) e.seg_length = chunk_len();
          e.op_ok = ($urandom_range(0, 19) != 0);
          e.validate_ok = ($urandom_range(0, 4) != 0);
        end else if (roll < 93) e.kind = KIND_TICK;
        else if (roll < 95) e.kind = KIND_ABORT;
        else begin
          e.kind = KIND_UPDATE;
          e.total_length = image_size();
        end
      end
    endcase
    return e;
  endfunction

  task automatic push_event(input in_item_t e, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t predicted;
    if ($urandom_range(0, 39) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_download(e);
    expected_actions.push_back(typed ? want : predicted);
    if (e.kind <= KIND_ABORT) n_items++;
  endtask

  // every item yields a result, so an empty queue means the block is idle
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wd,
                            output logic [31:0] rd);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wd;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] rd;
    settle();
    apb_access(1'b1, idx, {16'd0, val}, rd);
    apb_access(1'b0, idx, '0, rd);
    m_cfg[idx] = (idx == REG_MAX_ATT) ? {12'd0, val[3:0]} : val;
    if (rd !== {16'd0, m_cfg[idx]})
      log_mismatch($sformatf("register %0d readback", idx),
                   $sformatf("expected %h, got %h", {16'd0, m_cfg[idx]}, rd));
    n_writes++;
  endtask

  // output side: random stall before each result
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!(out_valid && !rst)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (out_data.action < 4'd12) seen_act[out_data.action] = 1'b1;
      if (expected_actions.size() == 0) begin
        log_mismatch("result with nothing expected", $sformatf("got %h", out_data));
      end else begin
        want = expected_actions.pop_front();
        if (want.action !== out_data.action || want.req_offset !== out_data.req_offset ||
            want.req_length !== out_data.req_length || want.phase_out !== out_data.phase_out)
          log_mismatch($sformatf("result %0d", n_results),
                       $sformatf("act/off/len/ph expected %0d/%h/%h/%0d, got %0d/%h/%h/%0d",
                                 want.action, want.req_offset, want.req_length, want.phase_out,
                                 out_data.action, out_data.req_offset, out_data.req_length,
                                 out_data.phase_out));
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [31:0] rd;
    logic [15:0] pw, cw, ma, cm;
    int quota;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 4; i++) begin
      apb_access(1'b0, 2'(i), '0, rd);
      if (rd !== {16'd0, m_cfg[i]})
        log_mismatch($sformatf("register %0d after reset", i),
                     $sformatf("expected %h, got %h", {16'd0, m_cfg[i]}, rd));
    end

    // wrong-phase events, unknown kind and abort while idle, then an announce and a failed enable
    add_event(ev(KIND_TICK, '0, '0, '0, 1'b0, 1'b0), 1, res(ACT_NONE, '0, '0, PH_IDLE));
    add_event(ev(KIND_SEGMENT, '1, '1, '1, 1'b1, 1'b1), 1, res(ACT_NONE, '0, '0, PH_IDLE));
    add_event(ev(KIND_ENABLE, '0, '0, '0, 1'b1, 1'b0), 1, res(ACT_NONE, '0, '0, PH_IDLE));
    add_event(ev(3'd7, '1, '1, '1, 1'b1, 1'b1), 1, res(ACT_NONE, '0, '0, PH_IDLE));
    add_event(ev(KIND_ABORT, '0, '0, '0, 1'b0, 1'b0), 1, res(ACT_ABORT, '0, '0, PH_IDLE));
    add_event(ev(KIND_UPDATE, '1, '0, '0, 1'b0, 1'b0), 1, res(ACT_ANNOUNCE, '0, '0, PH_WAIT));
    add_event(ev(KIND_ENABLE, '0, '0, '0, 1'b0, 1'b0), 1, res(ACT_INIT_FAIL, '0, '0, PH_IDLE));
    // update while busy restarts the wait; then a start, a misplaced segment, a next chunk and a write failure
    add_event(ev(KIND_UPDATE, 24'd10000, '0, '0, 1'b0, 1'b0), 1,
              res(ACT_ANNOUNCE, '0, '0, PH_WAIT));
    add_event(ev(KIND_UPDATE, 24'd5000, '0, '0, 1'b0, 1'b0), 1,
              res(ACT_ANNOUNCE, '0, '0, PH_WAIT));
    add_event(ev(KIND_ENABLE, '0, '0, '0, 1'b1, 1'b0), 1,
              res(ACT_START, '0, 16'd4096, PH_FETCH));
    add_event(ev(KIND_SEGMENT, '0, 24'd1, 16'd4096, 1'b1, 1'b1), 1,
              res(ACT_NONE, '0, '0, PH_FETCH));
    add_event(ev(KIND_SEGMENT, '0, '0, 16'd4096, 1'b1, 1'b0), 1,
              res(ACT_NEXT, 24'd4096, 16'd904, PH_FETCH));
    add_event(ev(KIND_SEGMENT, '0, 24'd4096, 16'd904, 1'b0, 1'b1), 1,
              res(ACT_WRITE_FAIL, '0, '0, PH_IDLE));
    // retry then give up, on an empty image
    add_reg(REG_CHUNK_WAIT, 16'd1);
    add_reg(REG_MAX_ATT, 16'd2);
    add_reg(REG_CHUNK_MAX, 16'hFFFF);
    add_event(ev(KIND_UPDATE, '0, '0, '0, 1'b0, 1'b0), 1, res(ACT_ANNOUNCE, '0, '0, PH_WAIT));
    add_event(ev(KIND_ENABLE, '0, '0, '0, 1'b1, 1'b0), 1, res(ACT_START, '0, '0, PH_FETCH));
    add_event(ev(KIND_TICK, '0, '0, '0, 1'b0, 1'b0), 1, res(ACT_RETRY, '0, '0, PH_FETCH));
    add_event(ev(KIND_TICK, '0, '0, '0, 1'b0, 1'b0), 1, res(ACT_GAVE_UP, '0, '0, PH_IDLE));
    // overshooting last segment with failed validation, then a permit timeout
    add_event(ev(KIND_UPDATE, 24'd70000, '0, '0, 1'b0, 1'b0), 1,
              res(ACT_ANNOUNCE, '0, '0, PH_WAIT));
    add_event(ev(KIND_ENABLE, '0, '0, '0, 1'b1, 1'b0), 1,
              res(ACT_START, '0, 16'hFFFF, PH_FETCH));
    add_event(ev(KIND_SEGMENT, '0, '0, '0, 1'b1, 1'b1), 1,
              res(ACT_NEXT, '0, 16'hFFFF, PH_FETCH));
    add_event(ev(KIND_SEGMENT, '0, '0, 16'hFFFF, 1'b1, 1'b1), 0, '0);
    add_event(ev(KIND_SEGMENT, '0, 24'd65535, 16'hFFFF, 1'b1, 1'b0), 1,
              res(ACT_VALIDATE_FAIL, '0, '0, PH_IDLE));
    add_reg(REG_PERMIT_WAIT, 16'd1);
    add_event(ev(KIND_UPDATE, 24'd1, '0, '0, 1'b0, 1'b0), 1, res(ACT_ANNOUNCE, '0, '0, PH_WAIT));
    add_event(ev(KIND_TICK, '0, '0, '0, 1'b0, 1'b0), 1,
              res(ACT_PERMIT_TIMEOUT, '0, '0, PH_IDLE));
    // a zero wait makes the timer wrap instead of timing out
    add_reg(REG_PERMIT_WAIT, 16'd0);
    add_event(ev(KIND_UPDATE, 24'd1, '0, '0, 1'b0, 1'b0), 1, res(ACT_ANNOUNCE, '0, '0, PH_WAIT));
    add_event(ev(KIND_TICK, '0, '0, '0, 1'b0, 1'b0), 1, res(ACT_NONE, '0, '0, PH_WAIT));
    add_event(ev(KIND_ENABLE, '0, '0, '0, 1'b1, 1'b0), 1, res(ACT_START, '0, 16'd1, PH_FETCH));
    add_event(ev(KIND_SEGMENT, '0, '0, 16'd1, 1'b1, 1'b1), 1, res(ACT_SUCCESS, '0, '0, PH_IDLE));

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].idx, script[i].val);
      else push_event(script[i].item, script[i].typed, script[i].want);
    end

    quota = n_items;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin pw = 16'd3; cw = 16'd2; ma = 16'd3; cm = 16'd4096; end
        1: begin pw = 16'd1; cw = 16'd1; ma = 16'd1; cm = 16'd1; end
        2: begin pw = 16'hFFFF; cw = 16'hFFFF; ma = 16'd15; cm = 16'hFFFF; end
        3: begin
          pw = 16'($urandom_range(2, 8));
          cw = 16'($urandom_range(1, 4));
          ma = 16'd15;
          cm = 16'($urandom_range(1, 3000));
        end
        default: begin
          pw = 16'($urandom_range(1, 10));
          cw = 16'($urandom_range(1, 6));
          ma = 16'($urandom_range(1, 15));
          cm = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 64)) : 16'($urandom);
          if (cm == '0) cm = 16'd1;
        end
      endcase
      write_reg(REG_PERMIT_WAIT, pw);
      write_reg(REG_CHUNK_WAIT, cw);
      write_reg(REG_MAX_ATT, ma);
      write_reg(REG_CHUNK_MAX, cm);
      if (p == 2) begin
        // full-size image so the offset climbs to the top and saturates
        push_event(ev(KIND_UPDATE, '1, '0, '0, 1'b0, 1'b0), 1'b0, '0);
        push_event(ev(KIND_ENABLE, '0, '0, '0, 1'b1, 1'b0), 1'b0, '0);
        while (m_phase == PH_FETCH) begin
          if ($urandom_range(0, 4) == 0)
            push_event(ev(KIND_TICK, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0);
          else
            push_event(ev(KIND_SEGMENT, '0, m_off,
                          ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF,
                          1'b1, 1'($urandom)), 1'b0, '0);
        end
      end
      quota += 220;
      while (n_items < quota) push_event(pick_event(), 1'b0, '0);
    end

    settle();
    repeat (4) @(posedge clk);
    $display("ran %0d items through %0d register writes, %0d results checked",
             n_items, n_writes, n_results);
    $display("action codes seen: %0d of 12", $countones(seen_act));
    if (n_mism == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: chunked_download_retry_controller_unit.f
hdl/cdrc_pkg.sv
hdl/cdrc_engine.sv
hdl/chunked_download_retry_controller_unit.sv
test/chunked_download_retry_controller_unit_tb.sv
